>>> sv/tlv_packet_field_locator_defines.svh
// Assertion macros shared by the field locator modules.
// Each macro expects i_clk and i_rst_n in the enclosing scope.
`ifndef TLV_PACKET_FIELD_LOCATOR_DEFINES_SVH
`define TLV_PACKET_FIELD_LOCATOR_DEFINES_SVH

// cond must hold at every edge out of reset
`define TLVPFL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define TLVPFL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define TLVPFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tlvpfl_pkg.sv
`timescale 1ns / 1ps

package tlvpfl_pkg;

    localparam int POS_W = 18;
    localparam logic [POS_W-1:0] POS_MAX = 18'h3FFFF;
    localparam logic [POS_W-1:0] FIXED_LEN = 18'd8;
    localparam logic [POS_W-1:0] WRAPPER_LEN = 18'd4;
    localparam logic [15:0] HEADER_REC_LEN = 16'd8;
    localparam logic [2:0] MAX_HITS = 3'd5;

    // packet type byte of the fixed header
    localparam logic [7:0] PKT_INTEREST = 8'h01;
    localparam logic [7:0] PKT_CONTENT = 8'h02;
    localparam logic [7:0] PKT_CONTROL = 8'hA4;

    // type codes of the type-length headers
    localparam logic [15:0] T_NAME = 16'h0000;
    localparam logic [15:0] T_KEYID = 16'h0001;
    localparam logic [15:0] T_OBJECT_HASH = 16'h0002;
    localparam logic [15:0] T_LIFETIME = 16'h0005;
    localparam logic [15:0] T_HOP_LIMIT = 16'h0002;
    localparam logic [15:0] T_NAME_AUTH = 16'h0002;
    localparam logic [15:0] T_CONTROL = 16'hBEEF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_PERHOP,
        PH_MSG,
        PH_INNER,
        PH_INNER_WAIT,
        PH_IDLE
    } t_phase;

    typedef enum logic [2:0] {
        REC_HEADER   = 3'd0,
        REC_HOPLIMIT = 3'd1,
        REC_NAME     = 3'd2,
        REC_KEYID    = 3'd3,
        REC_OBJHASH  = 3'd4,
        REC_LIFETIME = 3'd5,
        REC_CONTROL  = 3'd6,
        REC_END      = 3'd7
    } t_rec_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_VERSION = 2'd1,
        ST_SHORT   = 2'd2,
        ST_LONG    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       record_kind;
        logic [POS_W-1:0] value_offset;
        logic [15:0]      value_length;
        logic [7:0]       packet_kind;
        logic [POS_W-1:0] total_length;
        logic [15:0]      headers_length;
        logic [1:0]       status;
        logic             last_of_run;
    } t_out_item;

    // results of one byte; item1 is only used together with item0
    typedef struct packed {
        logic      push0;
        logic      push1;
        t_out_item item0;
        t_out_item item1;
    } t_push;

    // number of fields after which the message walk stops
    function automatic logic [2:0] hit_limit(input logic [7:0] kind);
        logic [2:0] lim;
        if (kind == PKT_INTEREST) begin
            lim = 3'd5;
        end else if (kind == PKT_CONTENT) begin
            lim = 3'd2;
        end else begin
            lim = 3'd1;
        end
        return lim;
    endfunction

endpackage

>>> sv/tlvpfl_parser.sv
`timescale 1ns / 1ps
`include "tlv_packet_field_locator_defines.svh"

module tlvpfl_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  tlvpfl_pkg::t_in_item i_item,
    output tlvpfl_pkg::t_push    o_push
);

    localparam int W = tlvpfl_pkg::POS_W;

    logic [W-1:0]          r_position;
    tlvpfl_pkg::t_phase    r_phase, n_phase;
    logic [63:0]           r_header, n_header;
    logic [23:0]           r_tl_gather, n_tl_gather;
    logic [1:0]            r_tl_index, n_tl_index;
    logic [W-1:0]          r_value_end, n_value_end;
    logic [W-1:0]          r_headers_end, n_headers_end;
    logic [W-1:0]          r_packet_end, n_packet_end;
    logic [W-1:0]          r_inner_end, n_inner_end;
    logic [2:0]            r_found, n_found;
    tlvpfl_pkg::t_status   r_end_status, n_end_status;

    // walk state after a section end has been resolved for this byte
    tlvpfl_pkg::t_phase    ph1;
    logic [W-1:0]          ve1;
    logic [2:0]            found1, found2;
    logic [1:0]            tli1;

    logic [7:0]            pkt;
    logic                  is_ic;
    logic [63:0]           header_shift;
    logic                  fixed_done;
    logic [31:0]           gather_new;
    logic [15:0]           tl_type, tl_len;
    logic [W-1:0]          value_off;
    logic                  wait_value, past_end, msg_stop;
    logic [2:0]            lim;
    logic                  take, complete, walk_emit, enter_inner, found_inc;
    tlvpfl_pkg::t_rec_kind walk_kind;
    logic                  has_a, fin;
    logic [W-1:0]          end_count;
    tlvpfl_pkg::t_status   end_status;
    tlvpfl_pkg::t_out_item rec_a, rec_end;

    assign pkt          = r_header[55:48];
    assign is_ic        = (pkt == tlvpfl_pkg::PKT_INTEREST) || (pkt == tlvpfl_pkg::PKT_CONTENT);
    assign header_shift = {r_header[55:0], i_item.data_byte};
    assign fixed_done   = (r_phase == tlvpfl_pkg::PH_FIXED)
                        && (r_position >= tlvpfl_pkg::FIXED_LEN - W'(1));
    assign gather_new   = {r_tl_gather, i_item.data_byte};
    assign tl_type      = gather_new[31:16];
    assign tl_len       = gather_new[15:0];
    assign value_off    = r_position + W'(1);
    assign lim          = tlvpfl_pkg::hit_limit(pkt);
    assign fin          = i_item.final_byte;

    // section end reached: move on before looking at this byte
    always_comb begin
        ph1    = r_phase;
        ve1    = r_value_end;
        found1 = r_found;
        tli1   = r_tl_index;
        if (r_phase == tlvpfl_pkg::PH_PERHOP && r_position >= r_headers_end) begin
            found1 = '0;
            tli1   = '0;
            if (is_ic) begin
                ve1 = r_headers_end + tlvpfl_pkg::WRAPPER_LEN;
                ph1 = tlvpfl_pkg::PH_MSG;
            end else if (pkt == tlvpfl_pkg::PKT_CONTROL) begin
                ve1 = r_headers_end;
                ph1 = tlvpfl_pkg::PH_MSG;
            end else begin
                ph1 = tlvpfl_pkg::PH_IDLE;
            end
        end else if ((r_phase == tlvpfl_pkg::PH_INNER || r_phase == tlvpfl_pkg::PH_INNER_WAIT)
                     && r_position >= r_inner_end) begin
            ph1  = tlvpfl_pkg::PH_MSG;
            ve1  = r_inner_end;
            tli1 = '0;
        end
    end

    assign wait_value = (tli1 == 2'd0) && (r_position < ve1);
    assign past_end   = r_position >= r_packet_end;
    assign msg_stop   = (ph1 == tlvpfl_pkg::PH_MSG) && !wait_value
                      && (past_end || (tli1 == 2'd0 && found1 >= lim));

    // byte take and field match
    always_comb begin
        take      = 1'b0;
        walk_emit = 1'b0;
        walk_kind = tlvpfl_pkg::REC_NAME;
        unique case (ph1)
            tlvpfl_pkg::PH_PERHOP: take = is_ic && (found1 == 3'd0) && !wait_value;
            tlvpfl_pkg::PH_MSG:    take = !wait_value && !msg_stop;
            tlvpfl_pkg::PH_INNER:  take = !past_end && !wait_value;
            default:               take = 1'b0;
        endcase
        complete = take && (tli1 == 2'd3);
        if (complete) begin
            unique case (ph1)
                tlvpfl_pkg::PH_PERHOP: begin
                    walk_emit = tl_type == tlvpfl_pkg::T_HOP_LIMIT;
                    walk_kind = tlvpfl_pkg::REC_HOPLIMIT;
                end
                tlvpfl_pkg::PH_MSG: begin
                    priority if (pkt == tlvpfl_pkg::PKT_INTEREST) begin
                        walk_emit = 1'b1;
                        priority if (tl_type == tlvpfl_pkg::T_NAME) begin
                            walk_kind = tlvpfl_pkg::REC_NAME;
                        end else if (tl_type == tlvpfl_pkg::T_KEYID) begin
                            walk_kind = tlvpfl_pkg::REC_KEYID;
                        end else if (tl_type == tlvpfl_pkg::T_OBJECT_HASH) begin
                            walk_kind = tlvpfl_pkg::REC_OBJHASH;
                        end else if (tl_type == tlvpfl_pkg::T_LIFETIME) begin
                            walk_kind = tlvpfl_pkg::REC_LIFETIME;
                        end else begin
                            walk_emit = 1'b0;
                        end
                    end else if (pkt == tlvpfl_pkg::PKT_CONTENT) begin
                        walk_emit = tl_type == tlvpfl_pkg::T_NAME;
                        walk_kind = tlvpfl_pkg::REC_NAME;
                    end else begin
                        walk_emit = tl_type == tlvpfl_pkg::T_CONTROL;
                        walk_kind = tlvpfl_pkg::REC_CONTROL;
                    end
                end
                tlvpfl_pkg::PH_INNER: begin
                    walk_emit = tl_type == tlvpfl_pkg::T_KEYID;
                    walk_kind = tlvpfl_pkg::REC_KEYID;
                end
                default: walk_emit = 1'b0;
            endcase
        end
    end

    assign enter_inner = complete && (ph1 == tlvpfl_pkg::PH_MSG)
                       && (pkt == tlvpfl_pkg::PKT_CONTENT) && (tl_type == tlvpfl_pkg::T_NAME_AUTH);
    // the name-authenticator section counts as a hit, the keyid inside it does not
    assign found_inc   = (walk_emit && ph1 != tlvpfl_pkg::PH_INNER) || enter_inner;
    assign found2      = found1 + 3'(found_inc);

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_header      = r_header;
        n_tl_gather   = r_tl_gather;
        n_tl_index    = r_tl_index;
        n_value_end   = r_value_end;
        n_headers_end = r_headers_end;
        n_packet_end  = r_packet_end;
        n_inner_end   = r_inner_end;
        n_found       = r_found;
        n_end_status  = r_end_status;
        if (r_phase == tlvpfl_pkg::PH_FIXED) begin
            n_header = header_shift;
            if (fixed_done) begin
                n_headers_end = tlvpfl_pkg::FIXED_LEN + W'(header_shift[15:0]);
                n_packet_end  = W'(header_shift[47:32]) + W'(header_shift[15:0])
                              + tlvpfl_pkg::FIXED_LEN;
                n_end_status  = (header_shift[63:56] != 8'd0) ? tlvpfl_pkg::ST_VERSION
                                                              : tlvpfl_pkg::ST_OK;
                n_found       = '0;
                n_tl_index    = '0;
                n_tl_gather   = '0;
                n_value_end   = tlvpfl_pkg::FIXED_LEN;
                n_phase       = tlvpfl_pkg::PH_PERHOP;
            end
        end else begin
            n_phase     = ph1;
            n_value_end = ve1;
            n_found     = found2;
            n_tl_index  = tli1;
            if (take) begin
                n_tl_gather = gather_new[23:0];
                n_tl_index  = complete ? 2'd0 : tli1 + 2'd1;
                if (complete) begin
                    n_value_end = value_off + W'(tl_len);
                end
            end
            unique case (ph1)
                tlvpfl_pkg::PH_MSG: begin
                    priority if (msg_stop) begin
                        n_tl_index = '0;
                        n_phase    = tlvpfl_pkg::PH_IDLE;
                    end else if (enter_inner) begin
                        n_inner_end = value_off + W'(tl_len);
                        n_value_end = value_off;
                        n_phase     = tlvpfl_pkg::PH_INNER;
                    end else if (complete && found2 >= lim) begin
                        n_phase = tlvpfl_pkg::PH_IDLE;
                    end
                end
                tlvpfl_pkg::PH_INNER: begin
                    priority if (past_end) begin
                        n_tl_index = '0;
                        n_phase    = tlvpfl_pkg::PH_IDLE;
                    end else if (walk_emit) begin
                        n_phase = tlvpfl_pkg::PH_INNER_WAIT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // records
    always_comb begin
        has_a     = fixed_done || walk_emit;
        end_count = (r_position < tlvpfl_pkg::POS_MAX) ? value_off : tlvpfl_pkg::POS_MAX;
        priority if (n_phase == tlvpfl_pkg::PH_FIXED || end_count < n_packet_end) begin
            end_status = tlvpfl_pkg::ST_SHORT;
        end else if (end_count > n_packet_end) begin
            end_status = tlvpfl_pkg::ST_LONG;
        end else begin
            end_status = n_end_status;
        end

        rec_a.record_kind    = fixed_done ? tlvpfl_pkg::REC_HEADER : walk_kind;
        rec_a.value_offset   = fixed_done ? '0 : value_off;
        rec_a.value_length   = fixed_done ? tlvpfl_pkg::HEADER_REC_LEN : tl_len;
        rec_a.packet_kind    = n_header[55:48];
        rec_a.total_length   = n_packet_end;
        rec_a.headers_length = n_header[15:0];
        rec_a.status         = tlvpfl_pkg::ST_OK;
        rec_a.last_of_run    = !fin;

        rec_end.record_kind  = tlvpfl_pkg::REC_END;
        rec_end.value_offset = end_count;
        rec_end.value_length = '0;
        if (n_phase != tlvpfl_pkg::PH_FIXED) begin
            rec_end.packet_kind    = n_header[55:48];
            rec_end.total_length   = n_packet_end;
            rec_end.headers_length = n_header[15:0];
        end else begin
            rec_end.packet_kind    = '0;
            rec_end.total_length   = '0;
            rec_end.headers_length = '0;
        end
        rec_end.status      = end_status;
        rec_end.last_of_run = 1'b1;

        o_push.push0 = i_accept && (has_a || fin);
        o_push.push1 = i_accept && has_a && fin;
        o_push.item0 = has_a ? rec_a : rec_end;
        o_push.item1 = rec_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && fin)) begin
            r_position    <= '0;
            r_phase       <= tlvpfl_pkg::PH_FIXED;
            r_header      <= '0;
            r_tl_gather   <= '0;
            r_tl_index    <= '0;
            r_value_end   <= '0;
            r_headers_end <= '0;
            r_packet_end  <= '0;
            r_inner_end   <= '0;
            r_found       <= '0;
            r_end_status  <= tlvpfl_pkg::ST_OK;
        end else if (i_accept) begin
            if (r_position < tlvpfl_pkg::POS_MAX) begin
                r_position <= value_off;
            end
            r_phase       <= n_phase;
            r_header      <= n_header;
            r_tl_gather   <= n_tl_gather;
            r_tl_index    <= n_tl_index;
            r_value_end   <= n_value_end;
            r_headers_end <= n_headers_end;
            r_packet_end  <= n_packet_end;
            r_inner_end   <= n_inner_end;
            r_found       <= n_found;
            r_end_status  <= n_end_status;
        end
    end

    `TLVPFL_ASSERT_IMPL(a_fixed_pos, r_phase == tlvpfl_pkg::PH_FIXED, r_position < tlvpfl_pkg::FIXED_LEN, "fixed header phase past byte 8")
    `TLVPFL_ASSERT_NEXT(a_hdr_done, i_accept && fixed_done && !fin, r_phase == tlvpfl_pkg::PH_PERHOP, "header did not start per-hop walk")
    `TLVPFL_ASSERT_IMPL(a_inner_content, r_phase == tlvpfl_pkg::PH_INNER || r_phase == tlvpfl_pkg::PH_INNER_WAIT, r_header[55:48] == tlvpfl_pkg::PKT_CONTENT, "inner walk outside content packet")
    `TLVPFL_ASSERT_ALWAYS(a_found_max, r_found <= tlvpfl_pkg::MAX_HITS, "hit count beyond limit")

endmodule

>>> sv/tlvpfl_out_queue.sv
`timescale 1ns / 1ps
`include "tlv_packet_field_locator_defines.svh"

module tlvpfl_out_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tlvpfl_pkg::t_push     i_push,
    input  logic                  i_pop,
    output tlvpfl_pkg::t_out_item o_item,
    output logic                  o_valid,
    output logic                  o_pair_room
);

    localparam int PW = tlvpfl_pkg::QPTR_W;
    localparam int CW = tlvpfl_pkg::QCNT_W;

    tlvpfl_pkg::t_out_item r_slots [tlvpfl_pkg::QUEUE_DEPTH];
    logic [PW-1:0]         r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]         r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]         r_count, n_count;

    assign o_item      = r_slots[r_rd_ptr];
    assign o_valid     = r_count != '0;
    // room for the two results a single byte can cause
    assign o_pair_room = r_count <= CW'(tlvpfl_pkg::QUEUE_DEPTH - 2);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push.push0) + PW'(i_push.push1);
        n_rd_ptr = r_rd_ptr + PW'(i_pop);
        n_count  = r_count + CW'(i_push.push0) + CW'(i_push.push1) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_slots[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.push1) begin
            r_slots[r_wr_ptr + PW'(1)] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `TLVPFL_ASSERT_ALWAYS(a_count_max, r_count <= CW'(tlvpfl_pkg::QUEUE_DEPTH), "result queue overflow")
    `TLVPFL_ASSERT_IMPL(a_pair_order, i_push.push1, i_push.push0, "second result pushed without first")
    `TLVPFL_ASSERT_IMPL(a_pair_fits, i_push.push0, o_pair_room, "push while queue lacks room")

endmodule

>>> sv/tlv_packet_field_locator.sv
`timescale 1ns / 1ps

// Streaming field locator for version-0 TLV packets. One packet byte is taken per cycle
// in wire order while input is not stalled; the fixed header yields a header record, and
// the per-hop, message and name-authenticator walks yield one record per field found
// (value offset and length), with an end record carrying the status on the byte marked
// final. Each byte is decoded in the cycle it is taken and its results are registered into
// a four-entry result queue, which offers them in order. Input runs at one byte per clock
// while the queue holds at most two results; the output drains one result per clock while
// i_out_stall is low. A byte may cause two results (a field or header record plus the end
// record), and input is stalled whenever the queue holds three or more.
module tlv_packet_field_locator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tlvpfl_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tlvpfl_pkg::t_out_item o_out_data
);

    logic              in_transfer;
    logic              out_transfer;
    logic              pair_room;
    tlvpfl_pkg::t_push push;

    assign o_in_stall   = !pair_room;
    assign in_transfer  = i_in_valid && pair_room;
    assign out_transfer = o_out_valid && !i_out_stall;

    tlvpfl_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_transfer),
        .i_item   (i_in_data),
        .o_push   (push)
    );

    tlvpfl_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (out_transfer),
        .o_item      (o_out_data),
        .o_valid     (o_out_valid),
        .o_pair_room (pair_room)
    );

endmodule
